>>> hdl/ptsc_pkg.sv
`timescale 1ns / 1ps
// ptsc_pkg: types, codes, reset values and small arithmetic helpers for the
// pan/tilt slew controller. No dependencies.

package ptsc_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE        = 2'd0,
    MODE_HOMING      = 2'd1,
    MODE_POSITIONING = 2'd2,
    MODE_TRACKING    = 2'd3
  } mode_t;

  // request codes
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_HOME   = 3'd1;
  localparam logic [2:0] REQ_SET    = 3'd2;
  localparam logic [2:0] REQ_TRACK  = 3'd3;
  localparam logic [2:0] REQ_VISION = 3'd4;
  localparam logic [2:0] REQ_STOP   = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_PAN_LO  = 3'd0;
  localparam logic [2:0] CFG_PAN_HI  = 3'd1;
  localparam logic [2:0] CFG_TILT_LO = 3'd2;
  localparam logic [2:0] CFG_TILT_HI = 3'd3;
  localparam logic [2:0] CFG_CX      = 3'd4;
  localparam logic [2:0] CFG_CY      = 3'd5;
  localparam logic [2:0] CFG_GAIN    = 3'd6;

  // per-tick step = speed / 100; 65535 / 100 = 655 fits in 10 bits
  localparam int STEP_W       = 10;
  localparam int DIV100_SHIFT = 23;
  localparam logic [32:0] DIV100_MUL = 33'd83887;  // ceil(2^23 / 100)

  typedef struct packed {
    logic signed [15:0] pan_lo;
    logic signed [15:0] pan_hi;
    logic signed [15:0] tilt_lo;
    logic signed [15:0] tilt_hi;
    logic [9:0]         cx;
    logic [9:0]         cy;
    logic [7:0]         gain;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         req;
    logic signed [15:0] pan_req;
    logic signed [15:0] tilt_req;
    logic [15:0]        speed;
    logic [9:0]         col;
    logic [9:0]         row;
  } item_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [15:0] pan_goal;
    logic signed [15:0] tilt_goal;
    logic signed [15:0] pan_pos;
    logic signed [15:0] tilt_pos;
    logic [STEP_W-1:0]  pan_step;
    logic [STEP_W-1:0]  tilt_step;
    logic               enabled;
    logic               tracking;
    logic               homed;
  } state_t;

  localparam cfg_t CFG_RESET = '{
    pan_lo:  -16'sd18000,
    pan_hi:  16'sd18000,
    tilt_lo: -16'sd4500,
    tilt_hi: 16'sd9000,
    cx:      10'd320,
    cy:      10'd240,
    gain:    8'd10
  };

  // speeds 3000 and 2000 at reset give steps of 30 and 20
  localparam state_t ST_RESET = '{
    mode:      MODE_IDLE,
    pan_goal:  16'sd0,
    tilt_goal: 16'sd0,
    pan_pos:   16'sd0,
    tilt_pos:  16'sd0,
    pan_step:  10'd30,
    tilt_step: 10'd20,
    enabled:   1'b0,
    tracking:  1'b0,
    homed:     1'b0
  };

  function automatic logic [STEP_W-1:0] div100(input logic [15:0] x);
    logic [32:0] p;
    p = {17'd0, x} * DIV100_MUL;
    return p[DIV100_SHIFT+STEP_W-1:DIV100_SHIFT];
  endfunction

  // lower bound first, then upper: inverted limits yield the upper limit
  function automatic logic signed [15:0] clamp(input logic signed [20:0] v,
                                               input logic signed [15:0] lo,
                                               input logic signed [15:0] hi);
    logic signed [20:0] r;
    logic signed [20:0] lo_w;
    logic signed [20:0] hi_w;
    lo_w = $signed({{5{lo[15]}}, lo});
    hi_w = $signed({{5{hi[15]}}, hi});
    r = v;
    if (r < lo_w) r = lo_w;
    if (r > hi_w) r = hi_w;
    return r[15:0];
  endfunction

  // one tick of motion toward goal, no overshoot
  function automatic logic signed [15:0] slew(input logic signed [15:0] pos,
                                              input logic signed [15:0] goal,
                                              input logic [STEP_W-1:0] step);
    logic signed [17:0] p;
    logic signed [17:0] g;
    logic signed [17:0] s;
    logic signed [17:0] up;
    logic signed [17:0] dn;
    logic signed [15:0] r;
    p  = $signed({{2{pos[15]}}, pos});
    g  = $signed({{2{goal[15]}}, goal});
    s  = $signed({{(18-STEP_W){1'b0}}, step});
    up = p + s;
    dn = p - s;
    r  = pos;
    if (p < g) begin
      r = (up < g) ? up[15:0] : goal;
    end else if (p > g) begin
      r = (dn > g) ? dn[15:0] : goal;
    end
    return r;
  endfunction

endpackage

>>> hdl/pan_tilt_slew_controller.sv
`timescale 1ns / 1ps
// pan_tilt_slew_controller: top level of the two-axis turret mode controller.
// Depends on ptsc_pkg, ptsc_cfg_regs, ptsc_update.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  event   | in_valid / in_ready   | req_type, pan_request, tilt_request,
//          |                       | speed_request, target_col, target_row
//  result  | out_valid / out_ready | mode, pan_position, tilt_position, pan_goal,
//          |                       | tilt_goal, drive_enabled, tracking_flag,
//          |                       | homed_flag
//  config  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One event beat per cycle sustained while out_ready stays high; a result is
// registered in the state registers from the event beat in the input register.
// The state registers double as the result register: state only advances
// when the result slot is empty or its beat is being taken.
// When the result stalls, the input register holds one more event beat and
// in_ready drops until the result drains.
// Synchronous reset restores the config defaults and the idle state; the
// result slot comes up empty. cfg_ready is always high.

module pan_tilt_slew_controller import ptsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // event channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         req_type,
  input  logic signed [15:0] pan_request,
  input  logic signed [15:0] tilt_request,
  input  logic [15:0]        speed_request,
  input  logic [9:0]         target_col,
  input  logic [9:0]         target_row,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         mode,
  output logic signed [15:0] pan_position,
  output logic signed [15:0] tilt_position,
  output logic signed [15:0] pan_goal,
  output logic signed [15:0] tilt_goal,
  output logic               drive_enabled,
  output logic               tracking_flag,
  output logic               homed_flag,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t   cfg;
  item_t  item;
  logic   in_full;
  logic   fire;      // input register's event is applied this cycle
  state_t st;
  state_t st_next;

  ptsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ptsc_update u_upd (
    .st      (st),
    .cfg     (cfg),
    .it      (item),
    .st_next (st_next)
  );

  assign fire     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || fire;

  // input register: one event beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= '{req: req_type, pan_req: pan_request, tilt_req: tilt_request,
                speed: speed_request, col: target_col, row: target_row};
    end
  end

  // state / result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_RESET;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign mode          = st.mode;
  assign pan_position  = st.pan_pos;
  assign tilt_position = st.tilt_pos;
  assign pan_goal      = st.pan_goal;
  assign tilt_goal     = st.tilt_goal;
  assign drive_enabled = st.enabled;
  assign tracking_flag = st.tracking;
  assign homed_flag    = st.homed;

endmodule

>>> hdl/ptsc_cfg_regs.sv
`timescale 1ns / 1ps
// ptsc_cfg_regs: configuration register file (limits, image center, gain).
// Depends on ptsc_pkg.

module ptsc_cfg_regs import ptsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PAN_LO:  cfg.pan_lo  <= $signed(cfg_data);
        CFG_PAN_HI:  cfg.pan_hi  <= $signed(cfg_data);
        CFG_TILT_LO: cfg.tilt_lo <= $signed(cfg_data);
        CFG_TILT_HI: cfg.tilt_hi <= $signed(cfg_data);
        CFG_CX:      cfg.cx      <= cfg_data[9:0];
        CFG_CY:      cfg.cy      <= cfg_data[9:0];
        CFG_GAIN:    cfg.gain    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hdl/ptsc_update.sv
`timescale 1ns / 1ps
// ptsc_update: next-state logic for one event (mode transitions, slew,
// clamped setpoints). Depends on ptsc_pkg.

module ptsc_update import ptsc_pkg::*; (
  input  state_t st,
  input  cfg_t   cfg,
  input  item_t  it,
  output state_t st_next
);

  logic signed [15:0] pan_slew;
  logic signed [15:0] tilt_slew;
  logic signed [10:0] err_x;
  logic signed [10:0] err_y;
  logic signed [19:0] prod_x;
  logic signed [19:0] prod_y;
  logic signed [20:0] sum_x;
  logic signed [20:0] sum_y;
  logic signed [15:0] set_pan;
  logic signed [15:0] set_tilt;

  always_comb begin
    pan_slew  = slew(st.pan_pos, st.pan_goal, st.pan_step);
    tilt_slew = slew(st.tilt_pos, st.tilt_goal, st.tilt_step);
    err_x  = $signed({1'b0, cfg.cx}) - $signed({1'b0, it.col});
    err_y  = $signed({1'b0, cfg.cy}) - $signed({1'b0, it.row});
    prod_x = err_x * $signed({1'b0, cfg.gain});
    prod_y = err_y * $signed({1'b0, cfg.gain});
    sum_x  = $signed({{5{st.pan_pos[15]}}, st.pan_pos}) + $signed({prod_x[19], prod_x});
    sum_y  = $signed({{5{st.tilt_pos[15]}}, st.tilt_pos}) + $signed({prod_y[19], prod_y});
    set_pan  = clamp($signed({{5{it.pan_req[15]}}, it.pan_req}), cfg.pan_lo, cfg.pan_hi);
    set_tilt = clamp($signed({{5{it.tilt_req[15]}}, it.tilt_req}), cfg.tilt_lo, cfg.tilt_hi);

    st_next = st;
    case (st.mode)
      MODE_IDLE: begin
        case (it.req)
          REQ_HOME: begin
            st_next.mode      = MODE_HOMING;
            st_next.enabled   = 1'b1;
            st_next.pan_goal  = '0;
            st_next.tilt_goal = '0;
          end
          REQ_SET: begin
            st_next.pan_goal  = set_pan;
            st_next.tilt_goal = set_tilt;
            if (it.speed != '0) begin
              st_next.pan_step  = div100(it.speed);
              st_next.tilt_step = div100(it.speed);
            end
            st_next.mode     = MODE_POSITIONING;
            st_next.enabled  = 1'b1;
            st_next.tracking = 1'b0;
          end
          REQ_TRACK: begin
            st_next.mode     = MODE_TRACKING;
            st_next.enabled  = 1'b1;
            st_next.tracking = 1'b1;
          end
          default: begin
          end
        endcase
      end
      MODE_HOMING: begin
        case (it.req)
          REQ_TICK: begin
            st_next.pan_pos  = pan_slew;
            st_next.tilt_pos = tilt_slew;
            if (pan_slew == '0 && tilt_slew == '0) begin
              st_next.homed   = 1'b1;
              st_next.mode    = MODE_IDLE;
              st_next.enabled = 1'b0;
            end
          end
          REQ_STOP: begin
            st_next.mode    = MODE_IDLE;
            st_next.enabled = 1'b0;
          end
          default: begin
          end
        endcase
      end
      MODE_POSITIONING: begin
        case (it.req)
          REQ_TICK: begin
            st_next.pan_pos  = pan_slew;
            st_next.tilt_pos = tilt_slew;
          end
          REQ_HOME: begin
            st_next.mode      = MODE_HOMING;
            st_next.enabled   = 1'b1;
            st_next.pan_goal  = '0;
            st_next.tilt_goal = '0;
          end
          REQ_SET: begin
            st_next.pan_goal  = set_pan;
            st_next.tilt_goal = set_tilt;
          end
          REQ_TRACK: begin
            st_next.mode     = MODE_TRACKING;
            st_next.enabled  = 1'b1;
            st_next.tracking = 1'b1;
          end
          REQ_STOP: begin
            st_next.mode    = MODE_IDLE;
            st_next.enabled = 1'b0;
          end
          default: begin
          end
        endcase
      end
      default: begin  // tracking
        case (it.req)
          REQ_TICK: begin
            st_next.pan_pos  = pan_slew;
            st_next.tilt_pos = tilt_slew;
          end
          REQ_HOME: begin
            st_next.mode      = MODE_HOMING;
            st_next.enabled   = 1'b1;
            st_next.pan_goal  = '0;
            st_next.tilt_goal = '0;
          end
          REQ_VISION: begin
            st_next.pan_goal  = clamp(sum_x, cfg.pan_lo, cfg.pan_hi);
            st_next.tilt_goal = clamp(sum_y, cfg.tilt_lo, cfg.tilt_hi);
          end
          REQ_STOP: begin
            st_next.mode    = MODE_IDLE;
            st_next.enabled = 1'b0;
          end
          default: begin
          end
        endcase
      end
    endcase
  end

endmodule

>>> hdl/ptsc_checker.sv
`timescale 1ns / 1ps
// ptsc_checker: port-level assertions for the pan/tilt slew controller,
// bound to the top level. Depends on ptsc_pkg.

module ptsc_checker import ptsc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         mode,
  input logic signed [15:0] pan_goal,
  input logic signed [15:0] tilt_goal,
  input logic               drive_enabled,
  input logic               tracking_flag
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mode) && $stable(pan_goal)
      && $stable(tilt_goal))
    else $error("result beat changed while stalled");

  // drive is on exactly outside idle
  a_enable: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((mode == MODE_IDLE) == !drive_enabled))
    else $error("drive_enabled disagrees with mode");

  // homing always targets zero
  a_home_goal: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode == MODE_HOMING |-> pan_goal == 16'sd0 && tilt_goal == 16'sd0)
    else $error("homing with nonzero setpoint");

  a_track_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode == MODE_TRACKING |-> tracking_flag)
    else $error("tracking mode without tracking flag");

endmodule

bind pan_tilt_slew_controller ptsc_checker u_chk (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for pan_tilt_slew_controller.
// Depends on ptsc_pkg (mode, request and register codes, reset config) and the DUT.

module tb_top;
  import ptsc_pkg::*;

  // unused request codes; the block must ignore them
  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;

  // slew speeds at reset, centidegrees per second
  localparam int PAN_SPEED_INIT  = 3000;
  localparam int TILT_SPEED_INIT = 2000;

  localparam int SPEED_DIV = 100;

  // one result beat, field order matches the port order used below
  typedef struct packed {
    mode_t              mode;
    logic signed [15:0] pan_pos;
    logic signed [15:0] tilt_pos;
    logic signed [15:0] pan_goal;
    logic signed [15:0] tilt_goal;
    logic               enabled;
    logic               tracking;
    logic               homed;
  } status_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         req_type;
  logic signed [15:0] pan_request;
  logic signed [15:0] tilt_request;
  logic [15:0]        speed_request;
  logic [9:0]         target_col;
  logic [9:0]         target_row;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         mode;
  logic signed [15:0] pan_position;
  logic signed [15:0] tilt_position;
  logic signed [15:0] pan_goal;
  logic signed [15:0] tilt_goal;
  logic               drive_enabled;
  logic               tracking_flag;
  logic               homed_flag;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  pan_tilt_slew_controller i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .pan_request   (pan_request),
    .tilt_request  (tilt_request),
    .speed_request (speed_request),
    .target_col    (target_col),
    .target_row    (target_row),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .mode          (mode),
    .pan_position  (pan_position),
    .tilt_position (tilt_position),
    .pan_goal      (pan_goal),
    .tilt_goal     (tilt_goal),
    .drive_enabled (drive_enabled),
    .tracking_flag (tracking_flag),
    .homed_flag    (homed_flag),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 50 MHz
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Turret state as the testbench sees it. Updated at the edge an event beat is
  // accepted, so the stimulus generator always picks from the current mode.
  // ---------------------------------------------------------------------------
  mode_t              m_mode;
  logic signed [15:0] m_pan_goal;
  logic signed [15:0] m_tilt_goal;
  logic signed [15:0] m_pan_pos;
  logic signed [15:0] m_tilt_pos;
  int                 m_pan_speed;
  int                 m_tilt_speed;
  bit                 m_drive_on;
  bit                 m_tracking;
  bit                 m_homed;

  // configuration copy
  int c_pan_lo, c_pan_hi, c_tilt_lo, c_tilt_hi;
  int c_cx, c_cy, c_gain;

  status_t pending_status[$];   // expected result beats, oldest first
  int      mismatches = 0;
  int      events_acted = 0;    // events that the block does not simply ignore
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  logic    out_hold = 1'b0;     // long receiver hold-off

  // lower bound first, then upper: inverted limits land on the upper one
  function automatic int bound(int v, int lo, int hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // one tick toward the goal, never past it; sums formed in 32 bits
  function automatic logic signed [15:0] step_toward(logic signed [15:0] pos,
                                                     logic signed [15:0] goal,
                                                     int speed);
    int p;
    int g;
    int s;
    p = int'(pos);
    g = int'(goal);
    s = speed / SPEED_DIV;
    if (p < g) p = (p + s < g) ? p + s : g;
    else if (p > g) p = (p - s > g) ? p - s : g;
    return p[15:0];
  endfunction

  function automatic void enter_mode(mode_t m);
    m_mode = m;
    case (m)
      MODE_IDLE: m_drive_on = 1'b0;
      MODE_HOMING: begin
        m_drive_on  = 1'b1;
        m_pan_goal  = '0;
        m_tilt_goal = '0;
      end
      MODE_POSITIONING: begin
        m_drive_on = 1'b1;
        m_tracking = 1'b0;
      end
      default: begin
        m_drive_on = 1'b1;
        m_tracking = 1'b1;
      end
    endcase
  endfunction

  function automatic void advance_axes();
    m_pan_pos  = step_toward(m_pan_pos, m_pan_goal, m_pan_speed);
    m_tilt_pos = step_toward(m_tilt_pos, m_tilt_goal, m_tilt_speed);
  endfunction

  function automatic void load_goals(item_t ev);
    m_pan_goal  = 16'(bound(int'(ev.pan_req), c_pan_lo, c_pan_hi));
    m_tilt_goal = 16'(bound(int'(ev.tilt_req), c_tilt_lo, c_tilt_hi));
  endfunction

  // Apply one event; returns the status beat it must produce. acted is low
  // when the event has no meaning in the current mode.
  function automatic status_t turret_step(input item_t ev, output bit acted);
    int ex;
    int ey;
    acted = 1'b1;
    case (m_mode)
      MODE_IDLE: begin
        if (ev.req == REQ_HOME) enter_mode(MODE_HOMING);
        else if (ev.req == REQ_SET) begin
          load_goals(ev);
          if (ev.speed != 0) begin
            m_pan_speed  = int'(ev.speed);
            m_tilt_speed = int'(ev.speed);
          end
          enter_mode(MODE_POSITIONING);
        end else if (ev.req == REQ_TRACK) enter_mode(MODE_TRACKING);
        else acted = 1'b0;
      end
      MODE_HOMING: begin
        if (ev.req == REQ_TICK) begin
          advance_axes();
          if (m_pan_pos == 0 && m_tilt_pos == 0) begin
            m_homed = 1'b1;
            enter_mode(MODE_IDLE);
          end
        end else if (ev.req == REQ_STOP) enter_mode(MODE_IDLE);
        else acted = 1'b0;
      end
      MODE_POSITIONING: begin
        if (ev.req == REQ_TICK) advance_axes();
        else if (ev.req == REQ_HOME) enter_mode(MODE_HOMING);
        else if (ev.req == REQ_SET) load_goals(ev);   // speeds stay put here
        else if (ev.req == REQ_TRACK) enter_mode(MODE_TRACKING);
        else if (ev.req == REQ_STOP) enter_mode(MODE_IDLE);
        else acted = 1'b0;
      end
      default: begin
        if (ev.req == REQ_TICK) advance_axes();
        else if (ev.req == REQ_HOME) enter_mode(MODE_HOMING);
        else if (ev.req == REQ_VISION) begin
          // wide sum, then saturate into the axis limits
          ex = c_cx - int'(ev.col);
          ey = c_cy - int'(ev.row);
          m_pan_goal  = 16'(bound(int'(m_pan_pos) + ex * c_gain, c_pan_lo, c_pan_hi));
          m_tilt_goal = 16'(bound(int'(m_tilt_pos) + ey * c_gain, c_tilt_lo, c_tilt_hi));
        end else if (ev.req == REQ_STOP) enter_mode(MODE_IDLE);
        else acted = 1'b0;
      end
    endcase
    return '{m_mode, m_pan_pos, m_tilt_pos, m_pan_goal, m_tilt_goal,
             m_drive_on, m_tracking, m_homed};
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [15:0] data);
    case (idx)
      CFG_PAN_LO:  c_pan_lo  = int'($signed(data));
      CFG_PAN_HI:  c_pan_hi  = int'($signed(data));
      CFG_TILT_LO: c_tilt_lo = int'($signed(data));
      CFG_TILT_HI: c_tilt_hi = int'($signed(data));
      CFG_CX:      c_cx      = int'(data[9:0]);
      CFG_CY:      c_cy      = int'(data[9:0]);
      CFG_GAIN:    c_gain    = int'(data[7:0]);
      default: ;
    endcase
  endfunction

  function automatic item_t mk(logic [2:0] req, int pan, int tilt, int speed,
                               int col, int row);
    item_t ev;
    ev.req      = req;
    ev.pan_req  = 16'(pan);
    ev.tilt_req = 16'(tilt);
    ev.speed    = 16'(speed);
    ev.col      = 10'(col);
    ev.row      = 10'(row);
    return ev;
  endfunction

  // Mostly events that make sense in the current mode, so homing completes,
  // moves settle and tracking runs; a slice of pure noise on top.
  function automatic item_t pick_event();
    item_t ev;
    int    r;
    ev.pan_req  = ($urandom_range(9) < 3) ? 16'($urandom)
                                          : 16'(int'($urandom_range(4000)) - 2000);
    ev.tilt_req = ($urandom_range(9) < 3) ? 16'($urandom)
                                          : 16'(int'($urandom_range(4000)) - 2000);
    case ($urandom_range(9))
      0:       ev.speed = 16'd0;
      1:       ev.speed = 16'($urandom);
      default: ev.speed = 16'($urandom_range(65535, 1500));
    endcase
    ev.col = 10'($urandom);
    ev.row = 10'($urandom);
    if ($urandom_range(99) < 8) begin
      ev.req = 3'($urandom_range(7));
    end else begin
      r = $urandom_range(99);
      case (m_mode)
        MODE_IDLE:
          ev.req = (r < 30) ? REQ_HOME : (r < 80) ? REQ_SET : REQ_TRACK;
        MODE_HOMING:
          ev.req = (r < 97) ? REQ_TICK : REQ_STOP;
        MODE_POSITIONING:
          ev.req = (r < 70) ? REQ_TICK : (r < 82) ? REQ_SET : (r < 87) ? REQ_HOME :
                   (r < 95) ? REQ_TRACK : REQ_STOP;
        default:
          ev.req = (r < 50) ? REQ_TICK : (r < 85) ? REQ_VISION : (r < 93) ? REQ_HOME :
                   REQ_STOP;
      endcase
    end
    return ev;
  endfunction

  function automatic string status_str(status_t s);
    return $sformatf("mode=%0d pan=%0d tilt=%0d pan_goal=%0d tilt_goal=%0d en=%0b trk=%0b hm=%0b",
                     s.mode, s.pan_pos, s.tilt_pos, s.pan_goal, s.tilt_goal,
                     s.enabled, s.tracking, s.homed);
  endfunction

  // ---------------------------------------------------------------------------
  // Event sender. Gaps drop valid; once raised, valid and payload hold until
  // the beat lands. The expectation is queued at the accepting edge.
  // ---------------------------------------------------------------------------
  task automatic send_event(input item_t ev);
    bit acted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= ev.req;
    pan_request   <= ev.pan_req;
    tilt_request  <= ev.tilt_req;
    speed_request <= ev.speed;
    target_col    <= ev.col;
    target_row    <= ev.row;
    do @(posedge clk); while (!in_ready);
    pending_status.push_back(turret_step(ev, acted));
    if (acted) events_acted++;
  endtask

  // stop offering events and let every expected beat come out
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, data);
  endtask

  // drains the expected result beats first, then writes every register
  task automatic program_settings(int plo, int phi, int tlo, int thi,
                                  int cx, int cy, int gain);
    drain();
    write_reg(CFG_PAN_LO, 16'(plo));
    write_reg(CFG_PAN_HI, 16'(phi));
    write_reg(CFG_TILT_LO, 16'(tlo));
    write_reg(CFG_TILT_HI, 16'(thi));
    write_reg(CFG_CX, 16'(cx));
    write_reg(CFG_CY, 16'(cy));
    write_reg(CFG_GAIN, 16'(gain));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random out_ready (or a forced hold-off) and the checker.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (out_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);

    if (!rst && out_valid && out_ready) begin
      got = '{mode_t'(mode), pan_position, tilt_position, pan_goal, tilt_goal,
              drive_enabled, tracking_flag, homed_flag};
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing expected: %s", $realtime, status_str(got));
      end else begin
        want = pending_status.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: status mismatch", $realtime);
            $display("  expected %s", status_str(want));
            $display("  actual   %s", status_str(got));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every request in every mode it matters in but stop while positioning (and
  // some where it does not), set-position clamping at the input extremes, speed
  // load only from idle, homing completion, and the unused request codes.
  task automatic test_mode_walk();
    send_event(mk(REQ_TICK, 0, 0, 0, 0, 0));            // idle: ignored
    send_event(mk(REQ_STOP, 0, 0, 0, 0, 0));            // idle: ignored
    send_event(mk(REQ_VISION, 0, 0, 0, 1023, 1023));    // vision outside tracking
    send_event(mk(REQ_SPARE6, -1, -1, 65535, 1023, 1023));
    send_event(mk(REQ_SPARE7, 0, 0, 0, 0, 0));
    send_event(mk(REQ_HOME, 0, 0, 0, 0, 0));
    send_event(mk(REQ_HOME, 0, 0, 0, 0, 0));            // home while homing
    send_event(mk(REQ_SET, 5, 5, 0, 0, 0));             // set while homing
    send_event(mk(REQ_TICK, 0, 0, 0, 0, 0));            // already at zero: homed
    // speed zero keeps 3000/2000; both requests clamp
    send_event(mk(REQ_SET, 32767, -32768, 0, 0, 0));
    send_event(mk(REQ_TICK, 0, 0, 0, 0, 0));
    // speed ignored once positioning
    send_event(mk(REQ_SET, -32768, 32767, 65535, 0, 0));
    send_event(mk(REQ_TICK, 0, 0, 0, 0, 0));
    send_event(mk(REQ_TRACK, 0, 0, 0, 0, 0));
    send_event(mk(REQ_SET, 100, 100, 100, 0, 0));       // set while tracking
    send_event(mk(REQ_TRACK, 0, 0, 0, 0, 0));           // track while tracking
    send_event(mk(REQ_VISION, 0, 0, 0, 0, 1023));
    send_event(mk(REQ_TICK, 0, 0, 0, 0, 0));
    send_event(mk(REQ_HOME, 0, 0, 0, 0, 0));            // tracking -> homing
    send_event(mk(REQ_STOP, 0, 0, 0, 0, 0));            // homing -> idle
    send_event(mk(REQ_SET, 100, -100, 65535, 0, 0));    // max speed loaded
    send_event(mk(REQ_HOME, 0, 0, 0, 0, 0));            // positioning -> homing
    send_event(mk(REQ_TICK, 0, 0, 0, 0, 0));            // one big step home
    send_event(mk(REQ_TRACK, 0, 0, 0, 0, 0));
    send_event(mk(REQ_STOP, 0, 0, 0, 0, 0));            // tracking -> idle
  endtask

  // Widest limits, largest gain, centers at the image corners: the vision
  // sum runs far past 16 bits and must saturate both ways.
  task automatic test_vision_saturation();
    program_settings(-32768, 32767, -32768, 32767, 0, 1023, 255);
    send_event(mk(REQ_TRACK, 0, 0, 0, 0, 0));
    send_event(mk(REQ_VISION, 0, 0, 0, 1023, 0));
    send_event(mk(REQ_TICK, 0, 0, 0, 0, 0));
    send_event(mk(REQ_TICK, 0, 0, 0, 0, 0));
    send_event(mk(REQ_VISION, 0, 0, 0, 0, 1023));       // zero error: goal = position
    send_event(mk(REQ_STOP, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic(int n);
    int goal_count;
    goal_count = events_acted + n;
    while (events_acted < goal_count) send_event(pick_event());
  endtask

  // Receiver holds off for a long stretch while events keep coming: the
  // result slot and the input register fill, and in_ready has to drop.
  task automatic test_backpressure();
    fork
      begin
        out_hold <= 1'b1;
        repeat (300) @(posedge clk);
        out_hold <= 1'b0;
      end
    join_none
    repeat (40) send_event(pick_event());
  endtask

  // lower above upper on both axes: every clamp lands on the upper limit
  task automatic test_inverted_limits();
    program_settings(5000, -5000, 3000, -3000, 512, 512, 37);
    send_event(mk(REQ_SET, 0, 0, 4000, 0, 0));
    test_random_traffic(150);
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    req_type      = '0;
    pan_request   = '0;
    tilt_request  = '0;
    speed_request = '0;
    target_col    = '0;
    target_row    = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;

    // power-on view of the block
    c_pan_lo     = int'(CFG_RESET.pan_lo);
    c_pan_hi     = int'(CFG_RESET.pan_hi);
    c_tilt_lo    = int'(CFG_RESET.tilt_lo);
    c_tilt_hi    = int'(CFG_RESET.tilt_hi);
    c_cx         = int'(CFG_RESET.cx);
    c_cy         = int'(CFG_RESET.cy);
    c_gain       = int'(CFG_RESET.gain);
    m_mode       = MODE_IDLE;
    m_pan_goal   = '0;
    m_tilt_goal  = '0;
    m_pan_pos    = '0;
    m_tilt_pos   = '0;
    m_pan_speed  = PAN_SPEED_INIT;
    m_tilt_speed = TILT_SPEED_INIT;
    m_drive_on   = 1'b0;
    m_tracking   = 1'b0;
    m_homed      = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender rarely idles, receiver often stalls
    send_idle_pct = 10;
    recv_idle_pct = 57;
    test_mode_walk();
    test_vision_saturation();
    program_settings(CFG_RESET.pan_lo, CFG_RESET.pan_hi, CFG_RESET.tilt_lo,
                     CFG_RESET.tilt_hi, CFG_RESET.cx, CFG_RESET.cy, CFG_RESET.gain);
    test_random_traffic(500);
    test_backpressure();

    // roles swapped: sender idles often, receiver rarely
    send_idle_pct = 57;
    recv_idle_pct = 10;
    program_settings(-int'($urandom_range(30000)), $urandom_range(30000),
                     -int'($urandom_range(30000)), $urandom_range(30000),
                     $urandom_range(1023), $urandom_range(1023), $urandom_range(255));
    test_random_traffic(450);
    test_inverted_limits();

    // full rate both ways; zero gain pins vision goals to the positions
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_settings(-32768, 32767, -32768, 32767, 1023, 0, 0);
    test_random_traffic(200);
    program_settings(-9000, 9000, -2000, 6000, 0, 1023, 255);
    test_random_traffic(300);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #(20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
